// ===== design/key_suffix_dedup_table_macros.svh =====
// ----------------------------------------------------------------------------
// Key suffix dedup table: assertion macros
// Concurrent assertion wrappers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef KEY_SUFFIX_DEDUP_TABLE_MACROS_SVH
`define KEY_SUFFIX_DEDUP_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define KSDT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KSDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KSDT_ASSERT(lbl, clk, rstn, prop, msg)

`define KSDT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/ksdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key suffix dedup table package
// Sizes, codes, controller/datapath command types and helper functions.
// ----------------------------------------------------------------------------
package ksdt_pkg;

    localparam int MAX_KEYS      = 64;
    localparam int MAX_REQ_SIGMA = 7;
    localparam int KEY_AW        = $clog2(MAX_KEYS);
    localparam int KEY_CW        = $clog2(MAX_KEYS + 1);
    localparam int TAIL_BYTES    = 8;
    localparam int BYTE_W        = 8;
    localparam int TAIL_W        = TAIL_BYTES * BYTE_W;
    localparam int LEN_W         = 4;
    localparam int REQ_W         = 3;
    localparam int NUM_W         = 6;
    localparam int SIG_W         = 4;
    localparam int ERR_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 3;

    localparam logic [BYTE_W-1:0] QUOTE_BYTE    = 8'h22;
    localparam logic [LEN_W-1:0]  LEN_MAX       = 4'hF;
    localparam logic [REQ_W-1:0]  REQ_SIGMA_RST = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUOTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA  = 2'd1;

    // result error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_KEYS  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic load;       // input request taken
        logic start;      // latch sigma and mask, rewind key pointer
        logic ld_err;     // load the error result
        logic key_rd;     // read the key tail table
        logic val_ld;     // mask the tail, rewind scan pointer
        logic uniq_rd;    // read the unique suffix table
        logic scan_next;  // step scan pointer
        logic add_new;    // store a new unique suffix and load its result
        logic hit;        // load a result for a matching suffix
        logic key_next;   // step key pointer
        logic clr_set;    // return set state to reset values
    } t_dp_cmd;

    typedef struct packed {
        logic [ERR_W-1:0] err_code;
        logic             scan_done;
        logic             match;
        logic             res_last;
    } t_dp_sts;

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] len);
        sat_inc = (len == LEN_MAX) ? LEN_MAX : len + LEN_W'(1);
    endfunction

    function automatic logic [SIG_W-1:0] calc_sigma(input logic [REQ_W-1:0] req,
                                                    input logic             quoted,
                                                    input logic [LEN_W-1:0] min_len);
        logic [SIG_W-1:0] req_c;
        logic [SIG_W-1:0] target;
        logic [SIG_W-1:0] sig;
        req_c = SIG_W'(req);
        if (req_c == '0) begin
            req_c = SIG_W'(1);
        end
        if (req_c > SIG_W'(MAX_REQ_SIGMA)) begin
            req_c = SIG_W'(MAX_REQ_SIGMA);
        end
        target = req_c + SIG_W'(quoted);
        sig    = (SIG_W'(min_len) < target) ? SIG_W'(min_len) : target;
        if (sig > SIG_W'(TAIL_BYTES)) begin
            sig = SIG_W'(TAIL_BYTES);
        end
        calc_sigma = sig;
    endfunction

    function automatic logic [TAIL_W-1:0] sigma_mask(input logic [SIG_W-1:0] sig);
        logic [TAIL_W-1:0] m;
        m = '0;
        for (int b = 0; b < TAIL_BYTES; b++) begin
            if (SIG_W'(b) < sig) begin
                m[b*BYTE_W +: BYTE_W] = '1;
            end
        end
        sigma_mask = m;
    endfunction

endpackage
`default_nettype wire

// ===== design/ksdt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key byte input channel
// Valid/ready channel carrying one key byte and the key and set markers.
// ----------------------------------------------------------------------------
interface ksdt_in_if;
    import ksdt_pkg::*;

    logic              valid;
    logic              ready;
    logic              has_byte;
    logic [BYTE_W-1:0] key_byte;
    logic              end_of_key;
    logic              end_of_set;

    modport source (output valid, has_byte, key_byte, end_of_key, end_of_set,
                    input ready);
    modport sink   (input valid, has_byte, key_byte, end_of_key, end_of_set,
                    output ready);
endinterface
`default_nettype wire

// ===== design/ksdt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix result output channel
// Valid/ready channel carrying one per-key suffix result or an error result.
// ----------------------------------------------------------------------------
interface ksdt_out_if;
    import ksdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  key_number;
    logic [NUM_W-1:0]  suffix_id;
    logic [TAIL_W-1:0] suffix_value;
    logic              is_new;
    logic [SIG_W-1:0]  compiled_sigma;
    logic [ERR_W-1:0]  error_code;
    logic              last_result;

    modport source (output valid, key_number, suffix_id, suffix_value, is_new,
                    compiled_sigma, error_code, last_result, input ready);
    modport sink   (input valid, key_number, suffix_id, suffix_value, is_new,
                    compiled_sigma, error_code, last_result, output ready);
endinterface
`default_nettype wire

// ===== design/key_suffix_dedup_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "key_suffix_dedup_table_macros.svh"
// ----------------------------------------------------------------------------
// Key suffix dedup table
// Usage:
//   Input channel i_in takes one request per cycle while loading: an optional
//   key byte, a key-close flag and a set-close flag. Config writes on i_cfg_*
//   (quoted mode, requested sigma) are taken in any cycle the block is idle.
//   After a set-close request, i_in.ready stays low while results stream out
//   on o_out: one result per loaded key in load order, or a single error
//   result. last_result marks the final one; loading resumes after it.
// Sequence:
//   Set close: a check state loads the error result or starts emission.
//   Each key result runs a key-table read, the mask step and a scan that
//   reads and compares the stored unique suffixes in turn until one
//   matches or none is left, when the suffix is stored as new; every
//   comparison costs one unique-table read and one compare step on the
//   single read port.
// Reset: clears all set state and returns config to defaults (plain mode,
//   requested sigma 4). The tables need no clearing pass.
// Stall: a result waits in the output register until o_out.ready is high.
// ----------------------------------------------------------------------------
module key_suffix_dedup_table (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [ksdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [ksdt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ksdt_in_if.sink                         i_in,
    ksdt_out_if.source                      o_out
);
    import ksdt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    ksdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_eos    (i_in.end_of_set),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    ksdt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_has_byte       (i_in.has_byte),
        .i_key_byte       (i_in.key_byte),
        .i_end_of_key     (i_in.end_of_key),
        .i_end_of_set     (i_in.end_of_set),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_key_number     (o_out.key_number),
        .o_suffix_id      (o_out.suffix_id),
        .o_suffix_value   (o_out.suffix_value),
        .o_is_new         (o_out.is_new),
        .o_compiled_sigma (o_out.compiled_sigma),
        .o_error_code     (o_out.error_code),
        .o_last_result    (o_out.last_result)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
`default_nettype wire

// ===== design/ksdt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "key_suffix_dedup_table_macros.svh"
// ----------------------------------------------------------------------------
// Key suffix dedup table controller
// Sequences loading, the set-end check, the per-key suffix scan and output.
// ----------------------------------------------------------------------------
module ksdt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_eos,
    input  wire               i_out_ready,
    input  wire ksdt_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ksdt_pkg::t_dp_cmd o_cmd
);
    import ksdt_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_KREAD = 3'd2;
    localparam logic [2:0] ST_KMASK = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_eos) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.err_code != ERR_OK) begin
                    o_cmd.ld_err = 1'b1;
                    n_state      = ST_OUT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_KREAD;
                end
            end
            ST_KREAD: begin
                o_cmd.key_rd = 1'b1;
                n_state      = ST_KMASK;
            end
            ST_KMASK: begin
                o_cmd.val_ld = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                // no stored suffix left to compare: this one is new
                if (i_sts.scan_done) begin
                    o_cmd.add_new = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    o_cmd.uniq_rd = 1'b1;
                    n_state       = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_OUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        o_cmd.clr_set = 1'b1;
                        n_state       = ST_LOAD;
                    end else begin
                        o_cmd.key_next = 1'b1;
                        n_state        = ST_KREAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `KSDT_ASSERT(a_eos_to_check, i_clk, i_rst_n,
        (r_state == ST_LOAD && i_in_valid && i_in_eos) |=> (r_state == ST_CHECK),
        "set end did not start the check")
    `KSDT_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_state == ST_OUT && !i_out_ready) |=> (r_state == ST_OUT),
        "result dropped while stalled")
    `KSDT_ASSERT(a_cmd_excl, i_clk, i_rst_n,
        $onehot0({o_cmd.key_rd, o_cmd.val_ld, o_cmd.uniq_rd, o_cmd.scan_next,
                  o_cmd.add_new, o_cmd.hit, o_cmd.ld_err, o_cmd.start}),
        "conflicting datapath commands")

endmodule
`default_nettype wire

// ===== design/ksdt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "key_suffix_dedup_table_macros.svh"
// ----------------------------------------------------------------------------
// Key suffix dedup table datapath
// Tail shift register, set statistics, key and unique-suffix tables, result.
// ----------------------------------------------------------------------------
module ksdt_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ksdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ksdt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_has_byte,
    input  wire  [ksdt_pkg::BYTE_W-1:0]         i_key_byte,
    input  wire                                 i_end_of_key,
    input  wire                                 i_end_of_set,
    input  wire  ksdt_pkg::t_dp_cmd             i_cmd,
    output ksdt_pkg::t_dp_sts                   o_sts,
    output logic [ksdt_pkg::NUM_W-1:0]          o_key_number,
    output logic [ksdt_pkg::NUM_W-1:0]          o_suffix_id,
    output logic [ksdt_pkg::TAIL_W-1:0]         o_suffix_value,
    output logic                                o_is_new,
    output logic [ksdt_pkg::SIG_W-1:0]          o_compiled_sigma,
    output logic [ksdt_pkg::ERR_W-1:0]          o_error_code,
    output logic                                o_last_result
);
    import ksdt_pkg::*;

    // configuration
    logic              r_quoted;
    logic [REQ_W-1:0]  r_req;

    // set state
    logic [TAIL_W-1:0] r_tail;
    logic [LEN_W-1:0]  r_len;
    logic [KEY_CW-1:0] r_key_cnt;
    logic [LEN_W-1:0]  r_min_len;
    logic              r_empty;
    logic              r_ovf;
    logic [KEY_CW-1:0] r_uniq_cnt;

    // emission
    logic [KEY_AW-1:0] r_key_idx;
    logic [KEY_CW-1:0] r_scan;
    logic [SIG_W-1:0]  r_sigma;
    logic [TAIL_W-1:0] r_mask;
    logic [TAIL_W-1:0] r_val;
    logic [TAIL_W-1:0] r_key_rd;
    logic [TAIL_W-1:0] r_uniq_rd;

    // result register
    logic [NUM_W-1:0]  r_res_num;
    logic [NUM_W-1:0]  r_res_id;
    logic [TAIL_W-1:0] r_res_val;
    logic              r_res_new;
    logic [SIG_W-1:0]  r_res_sig;
    logic [ERR_W-1:0]  r_res_err;
    logic              r_res_last;

    logic [TAIL_W-1:0] key_mem  [MAX_KEYS];
    logic [TAIL_W-1:0] uniq_mem [MAX_KEYS];

    logic [TAIL_W-1:0] tail_byte;
    logic [LEN_W-1:0]  len_byte;
    logic [TAIL_W-1:0] tail_closed;
    logic [LEN_W-1:0]  vlen;
    logic              kc_ok;
    logic              key_store;
    logic              is_last_key;
    logic [SIG_W-1:0]  sigma_c;
    logic [ERR_W-1:0]  err_c;

    always_comb begin
        tail_byte = i_has_byte ? {r_tail[TAIL_W-BYTE_W-1:0], i_key_byte} : r_tail;
        len_byte  = i_has_byte ? sat_inc(r_len) : r_len;
        // quoted keys carry a closing quote as their last virtual byte
        tail_closed = r_quoted ? {tail_byte[TAIL_W-BYTE_W-1:0], QUOTE_BYTE} : tail_byte;
        vlen        = r_quoted ? sat_inc(len_byte) : len_byte;
        kc_ok       = r_key_cnt < KEY_CW'(MAX_KEYS);
        key_store   = i_cmd.load && i_end_of_key && (len_byte != '0) && kc_ok;
        is_last_key = (KEY_CW'(r_key_idx) + KEY_CW'(1)) == r_key_cnt;
        sigma_c     = calc_sigma(r_req, r_quoted, r_min_len);
        if (r_key_cnt == '0 && !r_ovf) begin
            err_c = ERR_NO_KEYS;
        end else if (r_empty) begin
            err_c = ERR_EMPTY;
        end else if (r_ovf) begin
            err_c = ERR_OVERFLOW;
        end else begin
            err_c = ERR_OK;
        end
    end

    assign o_sts.err_code  = err_c;
    assign o_sts.scan_done = (r_scan == r_uniq_cnt);
    assign o_sts.match     = (r_uniq_rd == r_val);
    assign o_sts.res_last  = r_res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted   <= 1'b0;
            r_req      <= REQ_SIGMA_RST;
            r_tail     <= '0;
            r_len      <= '0;
            r_key_cnt  <= '0;
            r_min_len  <= LEN_MAX;
            r_empty    <= 1'b0;
            r_ovf      <= 1'b0;
            r_uniq_cnt <= '0;
            r_scan     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_QUOTED: r_quoted <= i_cfg_data[0];
                    REG_SIGMA:  r_req    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                // an unclosed key at set end is dropped
                if (i_end_of_key || i_end_of_set) begin
                    r_tail <= '0;
                    r_len  <= '0;
                end else begin
                    r_tail <= tail_byte;
                    r_len  <= len_byte;
                end
                if (i_end_of_key) begin
                    if (len_byte == '0) begin
                        r_empty <= 1'b1;
                        if (kc_ok) begin
                            r_key_cnt <= r_key_cnt + KEY_CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else if (!kc_ok) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_key_cnt <= r_key_cnt + KEY_CW'(1);
                        if (vlen < r_min_len) begin
                            r_min_len <= vlen;
                        end
                    end
                end
            end
            if (i_cmd.val_ld) begin
                r_scan <= '0;
            end
            if (i_cmd.scan_next) begin
                r_scan <= r_scan + KEY_CW'(1);
            end
            if (i_cmd.add_new) begin
                r_uniq_cnt <= r_uniq_cnt + KEY_CW'(1);
            end
            if (i_cmd.clr_set) begin
                r_key_cnt  <= '0;
                r_min_len  <= LEN_MAX;
                r_empty    <= 1'b0;
                r_ovf      <= 1'b0;
                r_uniq_cnt <= '0;
                r_scan     <= '0;
            end
        end
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (key_store) begin
            key_mem[r_key_cnt[KEY_AW-1:0]] <= tail_closed;
        end
        if (i_cmd.key_rd) begin
            r_key_rd <= key_mem[r_key_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_new) begin
            uniq_mem[r_uniq_cnt[KEY_AW-1:0]] <= r_val;
        end
        if (i_cmd.uniq_rd) begin
            r_uniq_rd <= uniq_mem[r_scan[KEY_AW-1:0]];
        end
    end

    // emission payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key_idx <= '0;
            r_sigma   <= sigma_c;
            r_mask    <= sigma_mask(sigma_c);
        end
        if (i_cmd.key_next) begin
            r_key_idx <= r_key_idx + KEY_AW'(1);
        end
        if (i_cmd.val_ld) begin
            r_val <= r_key_rd & r_mask;
        end
        if (i_cmd.ld_err) begin
            r_res_num  <= '0;
            r_res_id   <= '0;
            r_res_val  <= '0;
            r_res_new  <= 1'b0;
            r_res_sig  <= '0;
            r_res_err  <= err_c;
            r_res_last <= 1'b1;
        end
        if (i_cmd.add_new || i_cmd.hit) begin
            r_res_num  <= NUM_W'(r_key_idx);
            r_res_id   <= i_cmd.add_new ? NUM_W'(r_uniq_cnt) : NUM_W'(r_scan);
            r_res_val  <= r_val;
            r_res_new  <= i_cmd.add_new;
            r_res_sig  <= r_sigma;
            r_res_err  <= ERR_OK;
            r_res_last <= is_last_key;
        end
    end

    assign o_key_number     = r_res_num;
    assign o_suffix_id      = r_res_id;
    assign o_suffix_value   = r_res_val;
    assign o_is_new         = r_res_new;
    assign o_compiled_sigma = r_res_sig;
    assign o_error_code     = r_res_err;
    assign o_last_result    = r_res_last;

    `KSDT_ASSERT(a_key_cnt_max, i_clk, i_rst_n,
        r_key_cnt <= KEY_CW'(MAX_KEYS),
        "key count beyond table depth")
    `KSDT_ASSERT(a_uniq_le_keys, i_clk, i_rst_n,
        r_uniq_cnt <= r_key_cnt,
        "more unique suffixes than keys")
    `KSDT_ASSERT(a_scan_in_range, i_clk, i_rst_n,
        r_scan <= r_uniq_cnt,
        "scan pointer past stored suffixes")

endmodule
`default_nettype wire

// ===== sim/ksdt_suffix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key suffix dedup table: result checker
// Watches the key and result channels and the register port, predicts the
// suffix results of every closed key set and compares them in order.
// ----------------------------------------------------------------------------
module ksdt_suffix_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ksdt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [ksdt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ksdt_in_if                                i_key,
    ksdt_out_if                               i_res,
    output int                                o_pending,
    output int                                o_fail_count,
    output int                                o_checked
);
    import ksdt_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0]  key_number;
        logic [NUM_W-1:0]  suffix_id;
        logic [TAIL_W-1:0] suffix_value;
        logic              is_new;
        logic [SIG_W-1:0]  compiled_sigma;
        logic [ERR_W-1:0]  error_code;
        logic              last_result;
    } t_suffix_result;

    // register shadows
    logic             quoted_q;
    logic [REQ_W-1:0] req_sigma_q;

    // set state
    logic [TAIL_W-1:0] tail_tbl [MAX_KEYS];
    logic [TAIL_W-1:0] uniq_tbl [MAX_KEYS];
    logic [TAIL_W-1:0] cur_tail;
    int                cur_len;
    int                key_cnt;
    int                min_vlen;
    int                uniq_cnt;
    bit                empty_seen;
    bit                overflow_seen;

    t_suffix_result    suffix_results_q [$];

    task automatic clear_set_state();
        cur_tail      = '0;
        cur_len       = 0;
        key_cnt       = 0;
        min_vlen      = int'(LEN_MAX);
        uniq_cnt      = 0;
        empty_seen    = 1'b0;
        overflow_seen = 1'b0;
    endtask

    task automatic store_key_tail();
        logic [TAIL_W-1:0] tail;
        int                vlen;
        if (cur_len == 0) begin
            empty_seen = 1'b1;
            if (key_cnt < MAX_KEYS) begin
                key_cnt++;
            end else begin
                overflow_seen = 1'b1;
            end
        end else if (key_cnt >= MAX_KEYS) begin
            overflow_seen = 1'b1;
        end else begin
            tail = cur_tail;
            vlen = cur_len;
            // closing quote follows the key, mode as of this close
            if (quoted_q) begin
                tail = {tail[TAIL_W-BYTE_W-1:0], QUOTE_BYTE};
                if (vlen < int'(LEN_MAX)) begin
                    vlen++;
                end
            end
            tail_tbl[key_cnt] = tail;
            key_cnt++;
            if (vlen < min_vlen) begin
                min_vlen = vlen;
            end
        end
    endtask

    task automatic predict_set_results();
        t_suffix_result    res;
        logic [ERR_W-1:0]  err;
        logic [TAIL_W-1:0] mask;
        logic [TAIL_W-1:0] val;
        int                req;
        int                target;
        int                sig;
        int                id;
        bit                fresh;
        res = '0;
        err = ERR_OK;
        if (key_cnt == 0 && !overflow_seen) begin
            err = ERR_NO_KEYS;
        end else if (empty_seen) begin
            err = ERR_EMPTY;
        end else if (overflow_seen) begin
            err = ERR_OVERFLOW;
        end
        if (err != ERR_OK) begin
            res.error_code   = err;
            res.last_result  = 1'b1;
            suffix_results_q = {suffix_results_q, res};
            return;
        end
        req = (req_sigma_q == '0) ? 1 : int'(req_sigma_q);
        if (req > MAX_REQ_SIGMA) begin
            req = MAX_REQ_SIGMA;
        end
        target = req + (quoted_q ? 1 : 0);
        sig    = (min_vlen < target) ? min_vlen : target;
        if (sig > TAIL_BYTES) begin
            sig = TAIL_BYTES;
        end
        mask = (sig >= TAIL_BYTES) ? '1 : ((TAIL_W'(1) << (BYTE_W * sig)) - TAIL_W'(1));
        for (int k = 0; k < key_cnt; k++) begin
            val   = tail_tbl[k] & mask;
            id    = uniq_cnt;
            fresh = 1'b1;
            // first stored match wins
            for (int u = 0; u < uniq_cnt; u++) begin
                if (fresh && uniq_tbl[u] == val) begin
                    id    = u;
                    fresh = 1'b0;
                end
            end
            if (fresh) begin
                uniq_tbl[uniq_cnt] = val;
                uniq_cnt++;
            end
            res.key_number     = NUM_W'(k);
            res.suffix_id      = NUM_W'(id);
            res.suffix_value   = val;
            res.is_new         = fresh;
            res.compiled_sigma = SIG_W'(sig);
            res.error_code     = ERR_OK;
            res.last_result    = (k == key_cnt - 1);
            suffix_results_q   = {suffix_results_q, res};
        end
    endtask

    task automatic take_key_request();
        // byte first, then key close, then set close
        if (i_key.has_byte) begin
            cur_tail = {cur_tail[TAIL_W-BYTE_W-1:0], i_key.key_byte};
            if (cur_len < int'(LEN_MAX)) begin
                cur_len++;
            end
        end
        if (i_key.end_of_key) begin
            store_key_tail();
            cur_tail = '0;
            cur_len  = 0;
        end
        if (i_key.end_of_set) begin
            predict_set_results();
            clear_set_state();
        end
    endtask

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= 30) begin
            $display("[%0t] suffix result mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input logic [TAIL_W-1:0] got,
                               input logic [TAIL_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      o_checked, name, got, want));
        end
    endtask

    task automatic check_result();
        t_suffix_result want;
        if (suffix_results_q.size() == 0) begin
            report_mismatch($sformatf("result for key %0d with nothing pending",
                                      i_res.key_number));
            return;
        end
        want = suffix_results_q.pop_front();
        check_field("key_number",     TAIL_W'(i_res.key_number),     TAIL_W'(want.key_number));
        check_field("suffix_id",      TAIL_W'(i_res.suffix_id),      TAIL_W'(want.suffix_id));
        check_field("suffix_value",   i_res.suffix_value,            want.suffix_value);
        check_field("is_new",         TAIL_W'(i_res.is_new),         TAIL_W'(want.is_new));
        check_field("compiled_sigma", TAIL_W'(i_res.compiled_sigma), TAIL_W'(want.compiled_sigma));
        check_field("error_code",     TAIL_W'(i_res.error_code),     TAIL_W'(want.error_code));
        check_field("last_result",    TAIL_W'(i_res.last_result),    TAIL_W'(want.last_result));
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quoted_q    = 1'b0;
            req_sigma_q = REQ_SIGMA_RST;
            clear_set_state();
            suffix_results_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
            if (i_key.valid && i_key.ready) begin
                take_key_request();
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_QUOTED) begin
                    quoted_q = i_cfg_data[0];
                end else if (i_cfg_idx == REG_SIGMA) begin
                    req_sigma_q = i_cfg_data[REQ_W-1:0];
                end
            end
        end
        o_pending <= suffix_results_q.size();
    end

endmodule

// ===== sim/tb_key_suffix_dedup_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key suffix dedup table testbench
// Streams key sets into the table under changing register settings and
// idle mixes; the checker beside the table predicts and compares results.
// ----------------------------------------------------------------------------
module tb_key_suffix_dedup_table;
    import ksdt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_STALL   = 300;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ksdt_in_if  key_if ();
    ksdt_out_if res_if ();

    int pending;
    int fail_count;
    int checked_count;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_left   = 0;
    int cycle_cnt    = 0;
    int reqs_sent    = 0;
    int sets_sent    = 0;

    key_suffix_dedup_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (key_if),
        .o_out      (res_if)
    );

    ksdt_suffix_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_key        (key_if),
        .i_res        (res_if),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random back-pressure, or a counted hold-off when requested
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_req(input logic has_b, input logic [BYTE_W-1:0] kb,
                            input logic eok, input logic eos);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            key_if.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < src_idle_pct);
        end
        key_if.valid      <= 1'b1;
        key_if.has_byte   <= has_b;
        key_if.key_byte   <= kb;
        key_if.end_of_key <= eok;
        key_if.end_of_set <= eos;
        do begin
            @(posedge i_clk);
        end while (!key_if.ready);
        if (has_b || eok || eos) begin
            reqs_sent++;
        end
        if (eos) begin
            sets_sent++;
        end
    endtask

    // drop valid, let every pending result drain, then let the block settle
    task automatic wait_idle();
        key_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // single-byte keys with distinct bytes; one may be left empty
    task automatic send_wide_set(input int nkeys, input int empty_at);
        logic [BYTE_W-1:0] base;
        base = BYTE_W'($urandom);
        for (int k = 0; k < nkeys; k++) begin
            send_req(k != empty_at, base + BYTE_W'(k * 37), 1'b1, k == nkeys - 1);
        end
    endtask

    // keys share a few tail patterns behind random prefixes, so suffixes repeat
    task automatic send_random_set();
        logic [BYTE_W-1:0] pattern [3][8];
        int                pat_len [3];
        int                nkeys;
        int                empty_at;
        int                pre;
        int                pick;
        bit                trailing;
        bit                inline_close;
        bit                last_key;
        bit                last_b;
        nkeys    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
        empty_at = -1;
        if (nkeys > 0 && $urandom_range(0, 9) == 0) begin
            empty_at = $urandom_range(0, nkeys - 1);
        end
        trailing = (nkeys == 0) || ($urandom_range(0, 5) == 0);
        for (int p = 0; p < 3; p++) begin
            pat_len[p] = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4);
            for (int b = 0; b < 8; b++) begin
                pattern[p][b] = ($urandom_range(0, 3) == 0) ? QUOTE_BYTE : BYTE_W'($urandom);
            end
        end
        for (int k = 0; k < nkeys; k++) begin
            last_key = (k == nkeys - 1) && !trailing;
            if (k == empty_at) begin
                send_req(1'b0, BYTE_W'($urandom), 1'b1, last_key);
            end else begin
                pick         = $urandom_range(0, 2);
                pre          = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14)
                                                           : $urandom_range(0, 2);
                inline_close = ($urandom_range(0, 3) != 0);
                for (int b = 0; b < pre; b++) begin
                    send_req(1'b1, BYTE_W'($urandom), 1'b0, 1'b0);
                end
                for (int b = 0; b < pat_len[pick]; b++) begin
                    last_b = inline_close && (b == pat_len[pick] - 1);
                    if ($urandom_range(0, 15) == 0) begin
                        send_req(1'b0, BYTE_W'($urandom), 1'b0, 1'b0);
                    end
                    send_req(1'b1, pattern[pick][b], last_b, last_b && last_key);
                end
                if (!inline_close) begin
                    send_req(1'b0, BYTE_W'($urandom), 1'b1, last_key);
                end
            end
        end
        // unclosed bytes at set close are dropped
        if (trailing) begin
            repeat ($urandom_range(0, 3)) send_req(1'b1, BYTE_W'($urandom), 1'b0, 1'b0);
            send_req(1'($urandom_range(0, 1)), BYTE_W'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic run_directed();
        write_reg(REG_SPARE_A, 3'd7);
        write_reg(REG_SPARE_B, 3'd5);
        // empty set
        send_req(1'b0, 8'h00, 1'b0, 1'b1);
        // byte, key close and set close in one request
        send_req(1'b1, 8'hFF, 1'b1, 1'b1);
        // empty key
        send_req(1'b0, 8'h00, 1'b1, 1'b0);
        send_req(1'b1, 8'h00, 1'b0, 1'b0);
        send_req(1'b1, 8'h55, 1'b1, 1'b1);
        // two keys ending in the same byte, a bubble, and an unclosed key at set close
        send_req(1'b1, 8'h61, 1'b0, 1'b0);
        send_req(1'b1, 8'h62, 1'b1, 1'b0);
        send_req(1'b0, 8'hAA, 1'b0, 1'b0);
        send_req(1'b1, 8'h63, 1'b0, 1'b0);
        send_req(1'b1, 8'h62, 1'b1, 1'b0);
        send_req(1'b1, 8'h62, 1'b0, 1'b0);
        send_req(1'b1, 8'h64, 1'b1, 1'b0);
        send_req(1'b1, 8'h80, 1'b0, 1'b0);
        send_req(1'b1, 8'h7F, 1'b0, 1'b1);
        // quoted mode switched off between two keys of one set
        wait_idle();
        write_reg(REG_QUOTED, 3'd1);
        send_req(1'b1, 8'h71, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_QUOTED, 3'd0);
        send_req(1'b1, 8'h72, 1'b0, 1'b0);
        send_req(1'b1, 8'h73, 1'b1, 1'b0);
        send_req(1'b0, 8'h00, 1'b0, 1'b1);
        // requested length zero acts as one
        wait_idle();
        write_reg(REG_SIGMA, 3'd0);
        send_req(1'b1, 8'h78, 1'b0, 1'b0);
        send_req(1'b1, 8'h79, 1'b0, 1'b0);
        send_req(1'b1, 8'h7A, 1'b1, 1'b1);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int budget,
                             input logic [CFG_DATA_W-1:0] quoted,
                             input logic [CFG_DATA_W-1:0] sigma,
                             input int wide_keys, input int wide_empty_at,
                             input bit long_stall);
        int stop_at;
        wait_idle();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_reg(REG_QUOTED, quoted);
        write_reg(REG_SIGMA, sigma);
        stop_at = reqs_sent + budget;
        if (long_stall) begin
            stall_left = LONG_STALL;
        end
        send_wide_set(wide_keys, wide_empty_at);
        while (reqs_sent < stop_at) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                write_reg(REG_QUOTED, CFG_DATA_W'($urandom));
                write_reg(REG_SIGMA, CFG_DATA_W'($urandom));
            end
            send_random_set();
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        key_if.valid      <= 1'b0;
        key_if.has_byte   <= 1'b0;
        key_if.key_byte   <= '0;
        key_if.end_of_key <= 1'b0;
        key_if.end_of_set <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        // too many keys
        run_phase(19, 72, 80, 3'd1, 3'd7, MAX_KEYS + 1, -1, 1'b1);
        // empty key past a full table: empty wins over overflow
        run_phase(72, 19, 65, 3'd6, 3'd1, MAX_KEYS + 1, MAX_KEYS, 1'b0);
        // full table of distinct suffixes
        run_phase(0, 0, 70, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), MAX_KEYS, -1, 1'b0);

        wait_idle();
        $display("Ran %0d key sets (%0d requests), checked %0d results, %0d mismatches",
                 sets_sent, reqs_sent, checked_count, fail_count);
        $display("Covered error sets, mode and length settings, full table, overflow, stalls");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ksdt_pkg.sv
design/ksdt_in_if.sv
design/ksdt_out_if.sv
design/ksdt_ctrl.sv
design/ksdt_dp.sv
design/key_suffix_dedup_table.sv
sim/ksdt_suffix_checker.sv
sim/tb_key_suffix_dedup_table.sv
